// ===== rtl/c8x_pkg.sv =====
`timescale 1ns / 1ps

package c8x_pkg;

    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  random_byte;
    } t_in;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        write_valid;
        logic [3:0]  write_index;
        logic [7:0]  write_value;
        logic        flag_valid;
        logic        flag_value;
        logic [11:0] index_value;
        logic        clear_screen;
        logic [1:0]  stack_fault;
        logic        unhandled;
    } t_out;

    typedef enum logic [3:0] {
        K_CLS,
        K_RET,
        K_JP,
        K_CALL,
        K_SE_I,
        K_SNE_I,
        K_SE_R,
        K_SNE_R,
        K_LD_I,
        K_ADD_I,
        K_ALU,
        K_LD_IDX,
        K_JP_V0,
        K_RND,
        K_UNH
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [11:0] nnn;
        logic [7:0]  rnd;
    } t_dec;

    localparam logic [15:0] C_CLS_WORD = 16'h00E0;
    localparam logic [15:0] C_RET_WORD = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] C_VF = 4'hF;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_FULL  = 2'd1;
    localparam logic [1:0] FAULT_EMPTY = 2'd2;

    localparam logic [11:0] C_PC_RESET = 12'd512;
    localparam logic        REG_PROG_START = 1'b0;

endpackage

// ===== rtl/c8x_ram.sv =====
`timescale 1ns / 1ps

module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/c8x_front.sv =====
`timescale 1ns / 1ps

module c8x_front (
    input  c8x_pkg::t_in  i_data,
    output c8x_pkg::t_dec o_dec
);
    import c8x_pkg::*;

    logic [15:0] w;
    t_kind       kind;

    assign w = i_data.instruction;

    always_comb begin
        case (w[15:12])
            4'h0: begin
                if (w == C_CLS_WORD) kind = K_CLS;
                else if (w == C_RET_WORD) kind = K_RET;
                else kind = K_UNH;
            end
            4'h1: kind = K_JP;
            4'h2: kind = K_CALL;
            4'h3: kind = K_SE_I;
            4'h4: kind = K_SNE_I;
            4'h5: kind = K_SE_R;
            4'h6: kind = K_LD_I;
            4'h7: kind = K_ADD_I;
            4'h8: begin
                if (w[3] == 1'b0 || w[3:0] == ALU_SHL) kind = K_ALU;
                else kind = K_UNH;
            end
            4'h9: kind = (w[3:0] == 4'h0) ? K_SNE_R : K_UNH;
            4'hA: kind = K_LD_IDX;
            4'hB: kind = K_JP_V0;
            4'hC: kind = K_RND;
            default: kind = K_UNH;
        endcase
    end

    assign o_dec.kind = kind;
    assign o_dec.x    = w[11:8];
    assign o_dec.y    = w[7:4];
    assign o_dec.n    = w[3:0];
    assign o_dec.nnn  = w[11:0];
    assign o_dec.rnd  = i_data.random_byte;
endmodule

// ===== rtl/c8x_queue.sv =====
`timescale 1ns / 1ps

module c8x_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c8x_pkg::t_dec i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output c8x_pkg::t_dec o_data
);
    import c8x_pkg::*;

    t_dec       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wptr] <= i_data;
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
endmodule

// ===== rtl/c8x_back.sv =====
`timescale 1ns / 1ps

module c8x_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  c8x_pkg::t_dec i_q_data,
    output logic          o_pop,
    output logic          o_valid,
    output c8x_pkg::t_out o_data,
    input  logic          i_stall
);
    import c8x_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // execute stage
    logic        r_b_valid;
    t_dec        r_b;
    logic        b_fire;
    logic        load;

    // architectural state
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_idx, n_idx;
    logic [7:0]  r_vf, n_vf;
    logic [7:0]  r_v0;
    logic [LW-1:0] r_level, n_level;
    // V registers not yet written since reset read as zero
    logic [15:0] r_vw;

    // last register-file and stack writes, for read-during-write forwarding
    logic        r_byp;
    logic [3:0]  r_byp_x;
    logic [7:0]  r_byp_val;
    logic        r_push;
    logic [11:0] r_push_data;

    logic        r_o_valid;
    t_out        r_o_data;
    t_out        res;

    logic [3:0]  rd_x, rd_y;
    logic [7:0]  qx, qy;
    logic [7:0]  vx, vy;
    logic [11:0] stk_q, top;
    logic [LW-1:0] lvl_m1;
    logic        rf_we;
    logic        push;
    logic [11:0] pc2, pc4;
    logic [8:0]  sum9;
    logic        wv, fv, fval, reg_last;
    logic [7:0]  wval;

    assign b_fire = r_b_valid && (!r_o_valid || !i_stall);
    assign load   = i_q_valid && (!r_b_valid || b_fire);
    assign o_pop  = load;

    assign rd_x = load ? i_q_data.x : r_b.x;
    assign rd_y = load ? i_q_data.y : r_b.y;

    assign rf_we = b_fire && wv && (r_b.x != C_VF);

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_rf_x (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_b.x),
        .i_wdata (wval),
        .i_raddr (rd_x),
        .o_rdata (qx)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_rf_y (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_b.x),
        .i_wdata (wval),
        .i_raddr (rd_y),
        .o_rdata (qy)
    );

    assign lvl_m1 = n_level - {{(LW-1){1'b0}}, 1'b1};

    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (b_fire && push),
        .i_waddr (r_level[AW-1:0]),
        .i_wdata (pc2),
        .i_raddr (lvl_m1[AW-1:0]),
        .o_rdata (stk_q)
    );

    always_comb begin
        if (r_b.x == C_VF) vx = r_vf;
        else if (r_byp && r_byp_x == r_b.x) vx = r_byp_val;
        else if (!r_vw[r_b.x]) vx = 8'd0;
        else vx = qx;
        if (r_b.y == C_VF) vy = r_vf;
        else if (r_byp && r_byp_x == r_b.y) vy = r_byp_val;
        else if (!r_vw[r_b.y]) vy = 8'd0;
        else vy = qy;
    end

    assign top  = r_push ? r_push_data : stk_q;
    assign pc2  = r_pc + 12'd2;
    assign pc4  = r_pc + 12'd4;
    assign sum9 = {1'b0, vx} + {1'b0, vy};

    always_comb begin
        wv       = 1'b0;
        fv       = 1'b0;
        fval     = 1'b0;
        wval     = 8'd0;
        reg_last = 1'b1;
        push     = 1'b0;
        n_pc     = pc2;
        n_idx    = r_idx;
        n_level  = r_level;
        res      = '0;
        case (r_b.kind)
            K_CLS: res.clear_screen = 1'b1;
            K_RET: begin
                if (r_level == '0) begin
                    res.stack_fault = FAULT_EMPTY;
                end else begin
                    n_level = r_level - {{(LW-1){1'b0}}, 1'b1};
                    n_pc    = top;
                end
            end
            K_JP: n_pc = r_b.nnn;
            K_CALL: begin
                if (r_level == LW'(STACK_DEPTH)) begin
                    res.stack_fault = FAULT_FULL;
                end else begin
                    push    = 1'b1;
                    n_level = r_level + {{(LW-1){1'b0}}, 1'b1};
                    n_pc    = r_b.nnn;
                end
            end
            K_SE_I:  if (vx == r_b.nnn[7:0]) n_pc = pc4;
            K_SNE_I: if (vx != r_b.nnn[7:0]) n_pc = pc4;
            K_SE_R:  if (vx == vy) n_pc = pc4;
            K_SNE_R: if (vx != vy) n_pc = pc4;
            K_LD_I: begin
                wv = 1'b1; wval = r_b.nnn[7:0];
            end
            K_ADD_I: begin
                wv = 1'b1; wval = vx + r_b.nnn[7:0];
            end
            K_ALU: begin
                wv = 1'b1;
                case (r_b.n)
                    ALU_MOV: wval = vy;
                    ALU_OR:  wval = vx | vy;
                    ALU_AND: wval = vx & vy;
                    ALU_XOR: wval = vx ^ vy;
                    ALU_ADD: begin
                        fv = 1'b1; wval = sum9[7:0]; fval = sum9[8];
                    end
                    ALU_SUB: begin
                        fv = 1'b1; wval = vx - vy; fval = !(vy > vx);
                    end
                    ALU_SHR: begin
                        fv = 1'b1; reg_last = 1'b0;
                        wval = {1'b0, vx[7:1]}; fval = vx[0];
                    end
                    ALU_SUBN: begin
                        fv = 1'b1; wval = vy - vx; fval = !(vy < vx);
                    end
                    ALU_SHL: begin
                        fv = 1'b1; reg_last = 1'b0;
                        wval = {vx[6:0], 1'b0}; fval = vx[7];
                    end
                    default: wv = 1'b0;
                endcase
            end
            K_LD_IDX: n_idx = r_b.nnn;
            K_JP_V0:  n_pc = {4'd0, r_v0} + r_b.nnn;
            K_RND: begin
                wv = 1'b1; wval = r_b.rnd & r_b.nnn[7:0];
            end
            default: res.unhandled = 1'b1;
        endcase

        // VF takes whichever write comes last in the instruction's order
        n_vf = r_vf;
        if (reg_last) begin
            if (fv) n_vf = {7'd0, fval};
            if (wv && r_b.x == C_VF) n_vf = wval;
        end else begin
            if (wv && r_b.x == C_VF) n_vf = wval;
            if (fv) n_vf = {7'd0, fval};
        end

        if (!b_fire) begin
            n_pc    = r_pc;
            n_idx   = r_idx;
            n_level = r_level;
            n_vf    = r_vf;
        end

        res.next_pc     = n_pc;
        res.write_valid = wv;
        res.write_index = wv ? r_b.x : 4'd0;
        res.write_value = wv ? wval : 8'd0;
        res.flag_valid  = fv;
        res.flag_value  = fv ? fval : 1'b0;
        res.index_value = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_pc      <= C_PC_RESET;
            r_idx     <= 12'd0;
            r_vf      <= 8'd0;
            r_v0      <= 8'd0;
            r_level   <= '0;
            r_vw      <= 16'd0;
            r_byp     <= 1'b0;
            r_push    <= 1'b0;
        end else begin
            if (load) r_b_valid <= 1'b1;
            else if (b_fire) r_b_valid <= 1'b0;
            if (b_fire) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
            r_pc    <= n_pc;
            r_idx   <= n_idx;
            r_vf    <= n_vf;
            r_level <= n_level;
            if (rf_we && r_b.x == 4'd0) r_v0 <= wval;
            if (rf_we) r_vw[r_b.x] <= 1'b1;
            r_byp  <= rf_we;
            r_push <= b_fire && push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_b <= i_q_data;
        if (b_fire) r_o_data <= res;
        r_byp_x     <= r_b.x;
        r_byp_val   <= wval;
        r_push_data <= pc2;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
endmodule

// ===== rtl/chip8_instruction_execute.sv =====
// An accepted transaction is registered in the decode queue, then in the execute stage,
// then in the output register, where its result shows.
// Throughput: one instruction per cycle when nothing downstream stalls, set by the single
// execute stage that reads and writes the V registers, index, pc and return stack.
// Reset (synchronous, active low): pc 512, V registers, index and stack level zero,
// program_start 512; the return stack is not cleared.
`timescale 1ns / 1ps

module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  c8x_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output c8x_pkg::t_out o_data,
    input  logic          i_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import c8x_pkg::*;

    t_dec        f_dec;
    t_dec        q_data;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    logic [11:0] r_prog_start;

    c8x_front u_front (
        .i_data (i_data),
        .o_dec  (f_dec)
    );

    c8x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_data  (f_dec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    c8x_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

    assign o_stall = q_full;

    // program_start is held for read back only; pc loads its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_start <= C_PC_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PROG_START) begin
            r_prog_start <= pwdata[11:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROG_START) ? {20'd0, r_prog_start} : 32'd0;

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.stack_fault != 2'd3)
        else $error("illegal stack fault code");

    a_unh_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.unhandled |->
            !o_data.write_valid && !o_data.flag_valid && !o_data.clear_screen)
        else $error("unhandled instruction has side effects");

    a_flag_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.flag_valid |-> o_data.write_valid)
        else $error("flag write without register write");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.write_valid |->
            o_data.write_index == 4'd0 && o_data.write_value == 8'd0)
        else $error("write fields not zero");

endmodule
